// File: sv/rfc_pkg.sv
// ============================================================================
// rfc_pkg: shared types and constants for the readout frame checker
// Transfer payload types, word kind and status codes, CRC-16 XOR equations.
// ============================================================================
package rfc_pkg;

    typedef struct packed {
        logic [63:0] data_word;
        logic        buffer_start;
    } in_item_t;

    typedef struct packed {
        logic [63:0] word_out;
        logic [2:0]  word_kind;
        logic        frame_done;
        logic [2:0]  frame_status;
    } out_item_t;

    typedef struct packed {
        logic        en;
        logic [3:0]  idx;
        logic [23:0] size;
    } slot_wr_t;

    localparam logic [2:0] KIND_HDR1    = 3'd0;
    localparam logic [2:0] KIND_HDR2    = 3'd1;
    localparam logic [2:0] KIND_DESC    = 3'd2;
    localparam logic [2:0] KIND_PAYLOAD = 3'd3;
    localparam logic [2:0] KIND_TRL1    = 3'd4;
    localparam logic [2:0] KIND_TRL2    = 3'd5;
    localparam logic [2:0] KIND_DISCARD = 3'd6;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_HEADER = 3'd1;
    localparam logic [2:0] ST_BAD_SLOT   = 3'd2;
    localparam logic [2:0] ST_BAD_MARKER = 3'd3;
    localparam logic [2:0] ST_BAD_CRC    = 3'd4;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd5;

    localparam logic [3:0]  HDR_MARKER = 4'h5;
    localparam logic [3:0]  TRL_MARKER = 4'hA;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [63:0] TRL2_CRC_MASK = 64'hFFFF_FFFF_0000_FFFF;
    localparam logic [24:0] CNT_MAX    = 25'h1FF_FFFF;

    // data bits feeding each CRC bit; CRC enters on data bits 63:48
    localparam logic [63:0] CRC_TAPS [16] = '{
        64'hF0FFEBFFCFFFBFFF, 64'hE1FFD7FF9FFF7FFE,
        64'h33004400F0014003, 64'h66008801E0028006,
        64'hCC011003C005000C, 64'h98022007800A0018,
        64'h3004400F00140030, 64'h6008801E00280060,
        64'hC011003C005000C0, 64'h8022007800A00180,
        64'h004400F001400300, 64'h008801E002800600,
        64'h011003C005000C00, 64'h022007800A001800,
        64'h04400F0014003000, 64'hF87FF5FFE7FFDFFF
    };

    function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [63:0] word);
        logic [63:0] x;
        logic [15:0] r;
        x = word ^ {crc, 48'd0};
        for (int i = 0; i < 16; i++)
        begin
            r[i] = ^(x & CRC_TAPS[i]);
        end
        return r;
    endfunction

endpackage

// File: sv/rfc_slot_table.sv
// ============================================================================
// rfc_slot_table: per-slot size store
// One size per slot, written by descriptors, read as a word enters the
// input register; a write to the same slot at that edge is forwarded.
// ============================================================================
module rfc_slot_table
    import rfc_pkg::*;
#(
    parameter int MAX_SLOTS = 12
)
(
    input  logic        clk,
    input  slot_wr_t    wr,
    input  logic        rd_en,
    input  logic [3:0]  rd_idx,
    output logic [23:0] rd_size
);

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    logic [23:0] size_reg [MAX_SLOTS];
    logic [23:0] rd_size_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            size_reg[wr.idx[IW-1:0]] <= wr.size;
        end
        if (rd_en)
        begin
            if (wr.en && wr.idx == rd_idx)
            begin
                rd_size_reg <= wr.size;
            end
            else
            begin
                rd_size_reg <= size_reg[rd_idx[IW-1:0]];
            end
        end
    end

    assign rd_size = rd_size_reg;

endmodule

// File: sv/rfc_parser.sv
// ============================================================================
// rfc_parser: frame parse state, CRC and length checks
// Computes one word's result and the next parse state in a single pass.
// ============================================================================
module rfc_parser
    import rfc_pkg::*;
#(
    parameter int MAX_SLOTS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic        load,
    input  logic [3:0]  load_slot,
    input  in_item_t    item,
    input  logic [11:0] expected_source_id,
    output out_item_t   result
);

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam logic [3:0] SLOT_LAST = 4'(MAX_SLOTS);

    localparam logic [2:0] PH_DISCARD = 3'd0;
    localparam logic [2:0] PH_HDR2    = 3'd1;
    localparam logic [2:0] PH_DESC    = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_TRL1    = 3'd4;
    localparam logic [2:0] PH_TRL2    = 3'd5;

    logic [2:0]           phase_reg, phase_next;
    logic [15:0]          crc_reg, crc_next_v;
    logic [24:0]          cnt_reg, cnt_next;
    logic [3:0]           desc_left_reg, desc_left_next;
    logic [MAX_SLOTS-1:0] seen_reg, seen_next;
    logic [27:0]          payload_left_reg, payload_left_next;

    logic [63:0] w;
    logic [63:0] crc_word;
    logic [15:0] crc_seed;
    logic [15:0] crc_calc;
    logic [24:0] cnt_inc;
    logic [3:0]  slot;
    logic [3:0]  slot_idx;
    logic [3:0]  load_idx;
    logic        slot_ok;
    logic [23:0] old_size;
    logic [23:0] rd_size;
    logic [27:0] sum_new;
    logic [27:0] payload_dec;
    logic [3:0]  desc_dec;
    slot_wr_t    slot_wr;

    assign load_idx = load_slot - 4'd1;

    rfc_slot_table #(.MAX_SLOTS(MAX_SLOTS)) u_slot_table
    (
        .clk     (clk),
        .wr      (slot_wr),
        .rd_en   (load),
        .rd_idx  (load_idx),
        .rd_size (rd_size)
    );

    assign w        = item.data_word;
    assign crc_word = (!item.buffer_start && phase_reg == PH_TRL2) ? (w & TRL2_CRC_MASK) : w;
    assign crc_seed = item.buffer_start ? CRC_INIT : crc_reg;
    assign crc_calc = crc_next(crc_seed, crc_word);
    assign cnt_inc  = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 25'd1;
    assign slot     = w[19:16];
    assign slot_idx = slot - 4'd1;
    assign slot_ok  = (slot != 4'd0) && (slot <= SLOT_LAST);
    assign old_size = seen_reg[slot_idx[IW-1:0]] ? rd_size : 24'd0;
    assign sum_new  = payload_left_reg - {4'd0, old_size} + {4'd0, w[55:32]};
    assign payload_dec = payload_left_reg - 28'd1;
    assign desc_dec    = desc_left_reg - 4'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        crc_next_v        = crc_reg;
        cnt_next          = cnt_reg;
        desc_left_next    = desc_left_reg;
        seen_next         = seen_reg;
        payload_left_next = payload_left_reg;
        slot_wr.en        = 1'b0;
        slot_wr.idx       = slot_idx;
        slot_wr.size      = w[55:32];
        result.word_out     = w;
        result.word_kind    = KIND_DISCARD;
        result.frame_done   = 1'b0;
        result.frame_status = ST_OK;

        if (item.buffer_start)
        begin
            result.word_kind = KIND_HDR1;
            if (w[63:60] != HDR_MARKER || w[19:8] != expected_source_id)
            begin
                result.frame_done   = 1'b1;
                result.frame_status = ST_BAD_HEADER;
                phase_next          = PH_DISCARD;
            end
            else
            begin
                crc_next_v = crc_calc;
                cnt_next   = 25'd1;
                phase_next = PH_HDR2;
            end
        end
        else
        begin
            case (phase_reg)
                PH_HDR2:
                begin
                    result.word_kind  = KIND_HDR2;
                    crc_next_v        = crc_calc;
                    cnt_next          = cnt_inc;
                    desc_left_next    = w[55:52];
                    seen_next         = '0;
                    payload_left_next = 28'd0;
                    phase_next        = (w[55:52] != 4'd0) ? PH_DESC : PH_TRL1;
                end
                PH_DESC:
                begin
                    result.word_kind = KIND_DESC;
                    crc_next_v       = crc_calc;
                    cnt_next         = cnt_inc;
                    if (!slot_ok)
                    begin
                        result.frame_done   = 1'b1;
                        result.frame_status = ST_BAD_SLOT;
                        phase_next          = PH_DISCARD;
                    end
                    else
                    begin
                        slot_wr.en        = 1'b1;
                        seen_next         = seen_reg
                                          | (MAX_SLOTS'(1) << slot_idx[IW-1:0]);
                        desc_left_next    = desc_dec;
                        payload_left_next = sum_new;
                        if (desc_dec == 4'd0)
                        begin
                            phase_next = (sum_new != 28'd0) ? PH_PAYLOAD : PH_TRL1;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    result.word_kind  = KIND_PAYLOAD;
                    crc_next_v        = crc_calc;
                    cnt_next          = cnt_inc;
                    payload_left_next = payload_dec;
                    if (payload_dec == 28'd0)
                    begin
                        phase_next = PH_TRL1;
                    end
                end
                PH_TRL1:
                begin
                    result.word_kind = KIND_TRL1;
                    crc_next_v       = crc_calc;
                    cnt_next         = cnt_inc;
                    phase_next       = PH_TRL2;
                end
                PH_TRL2:
                begin
                    result.word_kind  = KIND_TRL2;
                    result.frame_done = 1'b1;
                    crc_next_v        = crc_calc;
                    cnt_next          = cnt_inc;
                    phase_next        = PH_DISCARD;
                    if (w[63:60] != TRL_MARKER)
                    begin
                        result.frame_status = ST_BAD_MARKER;
                    end
                    else if (crc_calc != w[31:16])
                    begin
                        result.frame_status = ST_BAD_CRC;
                    end
                    else if (cnt_inc != {1'b0, w[55:32]})
                    begin
                        result.frame_status = ST_BAD_LENGTH;
                    end
                end
                default:
                begin
                    result.word_kind = KIND_DISCARD;
                end
            endcase
        end

        if (!step)
        begin
            slot_wr.en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_DISCARD;
            crc_reg          <= CRC_INIT;
            cnt_reg          <= 25'd0;
            desc_left_reg    <= 4'd0;
            seen_reg         <= '0;
            payload_left_reg <= 28'd0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            crc_reg          <= crc_next_v;
            cnt_reg          <= cnt_next;
            desc_left_reg    <= desc_left_next;
            seen_reg         <= seen_next;
            payload_left_reg <= payload_left_next;
        end
    end

endmodule

// File: sv/readout_frame_checker_crc16.sv
// ============================================================================
// readout_frame_checker_crc16: 64-bit readout frame checker with CRC-16
// Input register, single-pass parser, output register.
// ============================================================================
// Takes one 64-bit frame word per clock while the output is not stalled and
// returns it with its kind; the last word of a frame carries frame_done and
// the status. Each word is held in the input register and then moves to the
// output register once that register is empty or is being read.
// The per-word path is the 64-bit CRC XOR tree plus the running sum of slot
// sizes (one subtract and one add), both evaluated between the input and
// output registers; the stored slot size is read as the word enters the
// input register. The user must write expected_source_id through the cfg
// channel only while no words are in flight; the block does not enforce it.
module readout_frame_checker_crc16
    import rfc_pkg::*;
#(
    parameter int MAX_SLOTS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  in_item_t    item,
    output logic        result_valid,
    input  logic        result_ready,
    output out_item_t   result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data
);

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    logic [11:0] src_id_reg;
    logic        advance;
    logic        in_take;
    out_item_t   parsed;

    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready   = !in_valid_reg || advance;
    assign in_take      = item_valid && item_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;
    assign cfg_ready    = 1'b1;

    rfc_parser #(.MAX_SLOTS(MAX_SLOTS)) u_parser
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (advance),
        .load               (in_take),
        .load_slot          (item.data_word[19:16]),
        .item               (in_item_reg),
        .expected_source_id (src_id_reg),
        .result             (parsed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            src_id_reg    <= 12'd0;
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                src_id_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= item;
        end
        if (advance)
        begin
            out_item_reg <= parsed;
        end
    end

endmodule
